// ===== hw/rtl/lfu_pkg.sv =====
// Package for the LFU cache: payload types and opcode codes.
package lfu_pkg;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] key;
    logic [31:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lfu_rsp_t;
endpackage

// ===== hw/rtl/lfu_cache_lookup_replace_top.sv =====
// LFU cache top level: entry memory and the scan/update sequencer.
//  channel | dir | handshake            | payload
//  req     | in  | req_valid_i/stall_o   | lfu_req_t
//  rsp     | out | rsp_valid_o/stall_i   | lfu_rsp_t
//  cfg     | in  | cfg_we_i              | capacity_in_use (5 bits)
// A result beat becomes valid after a scan pass, which reads one entry per cycle,
// and then an update pass, which rewrites one entry per cycle.
// The next request is accepted only after the sequencer has returned to idle.
// Reset empties the table through valid flops; no clearing pass.
// A result holds in the output register while stalled; the next request
// is taken once the result register is free or being drained.
module lfu_cache_lookup_replace_top import lfu_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  lfu_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output lfu_rsp_t rsp_o,
  input  logic     cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  typedef struct packed {
    logic [31:0]            key;
    logic [31:0]            value;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [IW-1:0]          rank;
  } ent_t;

  ent_t mem [CAPACITY];
  ent_t rd_q;
  logic [CAPACITY-1:0] vld_q, vld_d;
  logic [4:0] cap_q;
  logic [OW-1:0] occ_q, occ_d;
  logic [2:0] st_q, st_d;
  logic [IW:0] ix_q, ix_d;
  logic [IW-1:0] raddr, waddr;
  logic we;
  ent_t wdata;
  lfu_req_t req_q;
  logic hit_q, hit_d, vic_ok_q, vic_ok_d, fr_ok_q, fr_ok_d;
  logic [IW-1:0] hix_q, hix_d, vix_q, vix_d, fix_q, fix_d, six_q, six_d;
  logic [IW-1:0] hrank_q, hrank_d, vrank_q, vrank_d;
  logic [COUNT_WIDTH-1:0] vcnt_q, vcnt_d;
  logic [31:0] hval_q, hval_d, vkey_q, vkey_d;
  logic ev_q, ev_d, ins_q, ins_d;
  logic rv_q;
  lfu_rsp_t rsp_q;
  logic [IW-1:0] pix_q;
  logic pv_q;
  logic [OW-1:0] effcap;

  always_comb begin
    if (cap_q == 5'd0) effcap = OW'(1);
    else if (32'(cap_q) > CAPACITY) effcap = OW'(CAPACITY);
    else effcap = OW'(cap_q);
  end

  assign req_stall_o = (st_q != S_IDLE) || (rv_q && rsp_stall_i);
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

  assign raddr = ix_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_comb begin
    st_d = st_q; ix_d = ix_q; vld_d = vld_q; occ_d = occ_q;
    hit_d = hit_q; hix_d = hix_q; hrank_d = hrank_q; hval_d = hval_q;
    vic_ok_d = vic_ok_q; vix_d = vix_q; vcnt_d = vcnt_q; vrank_d = vrank_q;
    vkey_d = vkey_q; fr_ok_d = fr_ok_q; fix_d = fix_q; six_d = six_q;
    ev_d = ev_q; ins_d = ins_q;
    we = 1'b0; waddr = pix_q; wdata = rd_q;
    case (st_q)
      S_IDLE: begin
        ix_d = '0;
        hit_d = 1'b0; vic_ok_d = 1'b0; fr_ok_d = 1'b0;
        if (req_valid_i && !req_stall_o) st_d = S_SCAN;
      end
      S_SCAN: begin
        if (pv_q) begin
          if (vld_q[pix_q]) begin
            if (!hit_q && rd_q.key == req_q.key) begin
              hit_d = 1'b1; hix_d = pix_q; hrank_d = rd_q.rank; hval_d = rd_q.value;
            end
            if (!vic_ok_q || rd_q.cnt < vcnt_q ||
                (rd_q.cnt == vcnt_q && rd_q.rank > vrank_q)) begin
              vic_ok_d = 1'b1; vix_d = pix_q; vcnt_d = rd_q.cnt;
              vrank_d = rd_q.rank; vkey_d = rd_q.key;
            end
          end else if (!fr_ok_q) begin
            fr_ok_d = 1'b1; fix_d = pix_q;
          end
        end
        if (ix_q == (IW+1)'(CAPACITY)) begin
          st_d = S_DEC;
        end else begin
          ix_d = ix_q + 1'b1;
        end
      end
      S_DEC: begin
        ev_d = 1'b0; ins_d = 1'b0;
        if (!hit_q && req_q.opcode == OP_PUT) begin
          if (occ_q >= effcap && vic_ok_q) begin
            ev_d = 1'b1; ins_d = 1'b1; six_d = vix_q;
          end else if (fr_ok_q) begin
            ins_d = 1'b1; six_d = fix_q;
          end
        end
        ix_d = '0;
        st_d = S_UPD;
      end
      S_UPD: begin
        if (pv_q) begin
          wdata = rd_q;
          if (hit_q) begin
            if (vld_q[pix_q] && rd_q.rank < hrank_q) wdata.rank = rd_q.rank + 1'b1;
            if (pix_q == hix_q) begin
              wdata.rank = '0;
              if (rd_q.cnt != CMAX) wdata.cnt = rd_q.cnt + 1'b1;
              if (req_q.opcode == OP_PUT) wdata.value = req_q.value;
            end
            we = vld_q[pix_q];
          end else if (ins_q) begin
            if (vld_q[pix_q]) begin
              if (ev_q && rd_q.rank > vrank_q) wdata.rank = rd_q.rank;
              else wdata.rank = rd_q.rank + 1'b1;
              we = 1'b1;
            end
            if (pix_q == six_q) begin
              wdata.key = req_q.key; wdata.value = req_q.value;
              wdata.cnt = COUNT_WIDTH'(1); wdata.rank = '0;
              we = 1'b1;
            end
          end
        end
        if (ix_q == (IW+1)'(CAPACITY)) begin
          if (ins_q) begin
            vld_d[six_q] = 1'b1;
            if (!ev_q) occ_d = occ_q + 1'b1;
          end
          st_d = S_DONE;
        end else begin
          ix_d = ix_q + 1'b1;
        end
      end
      S_DONE: if (!(rv_q && rsp_stall_i)) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ix_q <= '0; vld_q <= '0; occ_q <= '0; cap_q <= 5'd16;
      rv_q <= 1'b0; pv_q <= 1'b0; hit_q <= 1'b0; vic_ok_q <= 1'b0;
      fr_ok_q <= 1'b0; ev_q <= 1'b0; ins_q <= 1'b0;
    end else begin
      st_q <= st_d; ix_q <= ix_d; vld_q <= vld_d; occ_q <= occ_d;
      hit_q <= hit_d; vic_ok_q <= vic_ok_d; fr_ok_q <= fr_ok_d;
      ev_q <= ev_d; ins_q <= ins_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      pv_q <= ((st_q == S_SCAN) || (st_q == S_UPD)) &&
              (ix_q != (IW+1)'(CAPACITY)) && !(st_q == S_SCAN && st_d == S_DEC);
      if (st_q == S_DONE && !(rv_q && rsp_stall_i)) rv_q <= 1'b1;
      else if (rv_q && !rsp_stall_i) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= raddr;
    hix_q <= hix_d; hrank_q <= hrank_d; hval_q <= hval_d; vix_q <= vix_d;
    vcnt_q <= vcnt_d; vrank_q <= vrank_d; vkey_q <= vkey_d; fix_q <= fix_d;
    six_q <= six_d;
    if (req_valid_i && !req_stall_o) req_q <= req_i;
    if (st_q == S_DONE && !(rv_q && rsp_stall_i)) begin
      rsp_q.hit <= hit_q;
      rsp_q.read_value <= hit_q ? ((req_q.opcode == OP_GET) ? hval_q : '0)
                                : ((req_q.opcode == OP_GET) ? '1 : '0);
      rsp_q.evicted <= ev_q;
      rsp_q.evicted_key <= ev_q ? vkey_q : '0;
    end
  end
endmodule

// ===== hw/rtl/lfu_checker.sv =====
// Port-level checker for the LFU cache and its bind.
module lfu_checker import lfu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_valid_i,
  input logic     req_stall_o,
  input logic     rsp_valid_o,
  input logic     rsp_stall_i,
  input lfu_rsp_t rsp_o
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o)) else $error("rsp");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o) else $error("busy");
  a_ev_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.evicted |-> !rsp_o.hit && rsp_o.read_value == '0)
    else $error("evict");
  a_evk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.evicted |-> rsp_o.evicted_key == '0) else $error("evk");
endmodule

bind lfu_cache_lookup_replace_top lfu_checker u_lfu_checker (.*);
